@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. Defining ASSERT_OFF empties them all.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");
// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ sv/wcta_pkg.sv @@
// ----------------------------------------------------------------------------
// wcta_pkg
// Types, constants and helper functions of the two-stage Wolff cluster block.
// ----------------------------------------------------------------------------
package wcta_pkg;

    localparam int WCTA_SIDE = 32;
    localparam int OUT_W     = 15;
    localparam int D_W       = 19;
    localparam int ACC_W     = 40;
    localparam int MUL_A_W   = 29;
    localparam int MUL_B_W   = 19;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam longint unsigned EXP_STEP = 64'd4034748382;

    typedef enum logic [2:0] {
        CFG_ADD_PROB    = 3'd0,
        CFG_COUPLING_1  = 3'd1,
        CFG_COUPLING_2  = 3'd2,
        CFG_COUPLING_3  = 3'd3,
        CFG_TRIPLE      = 3'd4,
        CFG_INV_TEMP    = 3'd5,
        CFG_ORDER       = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [15:0] add_probability;
        logic [15:0] coupling_first;
        logic [15:0] coupling_second;
        logic [15:0] coupling_third;
        logic [15:0] triple_coupling;
        logic [15:0] inverse_temperature;
        logic [1:0]  coupling_order;
    } cfg_t;

    typedef struct packed {
        logic spin_we;
        logic spin_wd;
        logic trial_we;
        logic trial_wd;
        logic stack_we;
    } mem_ctl_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RAND,
        ST_SEED,
        ST_COPY,
        ST_PUSH0,
        ST_NB_RD,
        ST_NB_CHK,
        ST_POP,
        ST_POP_WAIT,
        ST_SUM,
        ST_MAC,
        ST_MAC_ACC,
        ST_SCALE,
        ST_TEST,
        ST_FINAL
    } state_t;

    typedef logic [15:0] exp_table_t [256];

    function automatic logic [31:0] xorshift32(input logic [31:0] s);
        logic [31:0] x;
        x = s ^ (s << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        return x;
    endfunction

    // exp(-i/16) in Q0.16, built by repeated multiplication with a Q0.32 step.
    function automatic exp_table_t build_exp_table();
        exp_table_t  tbl;
        logic [95:0] e;
        logic [95:0] r;
        e = 96'd1 << 32;
        for (int i = 0; i < 256; i++)
        begin
            r = (e + 96'h8000) >> 16;
            tbl[i] = (r > 96'd65535) ? 16'hFFFF : r[15:0];
            e = (e * 96'(EXP_STEP) + (96'd1 << 31)) >> 32;
        end
        return tbl;
    endfunction

    localparam exp_table_t EXP_TABLE = build_exp_table();

endpackage

@@ sv/wcta_mem.sv @@
// ----------------------------------------------------------------------------
// wcta_mem
// Spin lattice, trial lattice and site stack, each one write and one read port.
// ----------------------------------------------------------------------------
module wcta_mem
    import wcta_pkg::*;
#(
    parameter int SIDE = WCTA_SIDE,
    localparam int RW = $clog2(SIDE),
    localparam int AW = 2 * RW
)
(
    input  logic          clk,
    input  mem_ctl_t      mem_ctl,
    input  logic [AW-1:0] spin_ra,
    input  logic [AW-1:0] spin_wa,
    input  logic [AW-1:0] trial_ra,
    input  logic [AW-1:0] trial_wa,
    input  logic [AW-1:0] stack_ra,
    input  logic [AW-1:0] stack_wa,
    input  logic [AW-1:0] stack_wd,
    output logic          spin_rd,
    output logic          trial_rd,
    output logic [AW-1:0] stack_rd
);

    localparam int DEPTH = 2 ** AW;

    // Spin bit 1 stands for -1.
    logic          spin_mem  [DEPTH];
    logic          trial_mem [DEPTH];
    logic [AW-1:0] stack_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (mem_ctl.spin_we)
        begin
            spin_mem[spin_wa] <= mem_ctl.spin_wd;
        end
        spin_rd <= spin_mem[spin_ra];
    end

    always_ff @(posedge clk)
    begin
        if (mem_ctl.trial_we)
        begin
            trial_mem[trial_wa] <= mem_ctl.trial_wd;
        end
        trial_rd <= trial_mem[trial_ra];
    end

    always_ff @(posedge clk)
    begin
        if (mem_ctl.stack_we)
        begin
            stack_mem[stack_wa] <= stack_wd;
        end
        stack_rd <= stack_mem[stack_ra];
    end

endmodule

@@ sv/wcta_mult.sv @@
// ----------------------------------------------------------------------------
// wcta_mult
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module wcta_mult
    import wcta_pkg::*;
(
    input  logic                      clk,
    input  logic signed [MUL_A_W-1:0] mul_a,
    input  logic signed [MUL_B_W-1:0] mul_b,
    output logic signed [PROD_W-1:0]  mul_p
);

    always_ff @(posedge clk)
    begin
        mul_p <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end

endmodule

@@ sv/wcta_ctrl.sv @@
// ----------------------------------------------------------------------------
// wcta_ctrl
// Sequencer: lattice sweeps, cluster growth, energy sums and accept stages.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wcta_ctrl
    import wcta_pkg::*;
#(
    parameter int SIDE = WCTA_SIDE,
    localparam int RW = $clog2(SIDE),
    localparam int AW = 2 * RW
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      mode,
    input  logic [31:0]               random_seed,
    input  cfg_t                      cfg,
    output logic                      busy,
    output logic                      done,
    output logic                      accepted,
    output logic [OUT_W-1:0]          cluster_size,
    output logic [OUT_W-1:0]          abs_magnetization,
    output mem_ctl_t                  mem_ctl,
    output logic [AW-1:0]             spin_ra,
    output logic [AW-1:0]             spin_wa,
    output logic [AW-1:0]             trial_ra,
    output logic [AW-1:0]             trial_wa,
    output logic [AW-1:0]             stack_ra,
    output logic [AW-1:0]             stack_wa,
    output logic [AW-1:0]             stack_wd,
    input  logic                      spin_rd,
    input  logic                      trial_rd,
    input  logic [AW-1:0]             stack_rd,
    output logic signed [MUL_A_W-1:0] mul_a,
    output logic signed [MUL_B_W-1:0] mul_b,
    input  logic signed [PROD_W-1:0]  mul_p
);

    localparam int NSITES = SIDE * SIDE;
    localparam int CW     = $clog2(NSITES + 1);
    localparam logic [RW-1:0] LAST = RW'(SIDE - 1);
    localparam logic [ACC_W-1:0] X_LIMIT = ACC_W'(1) << 28;

    function automatic logic [RW-1:0] inc1(input logic [RW-1:0] x);
        return (x == LAST) ? '0 : x + 1'b1;
    endfunction

    function automatic logic [RW-1:0] dec1(input logic [RW-1:0] x);
        return (x == '0) ? LAST : x - 1'b1;
    endfunction

    // v*a + v*b for spins coded as 1 = -1.
    function automatic logic signed [3:0] psum(input logic v, input logic a, input logic b);
        logic [1:0] n;
        n = {1'b0, v ^ a} + {1'b0, v ^ b};
        return 4'sd2 - $signed({1'b0, n, 1'b0});
    endfunction

    function automatic logic [OUT_W-1:0] mag_of(input logic [CW-1:0] c);
        logic signed [CW+1:0] m;
        m = $signed({1'b0, c, 1'b0}) - (CW+2)'(NSITES);
        if (m < 0)
        begin
            m = -m;
        end
        return OUT_W'(m);
    endfunction

    state_t                  state_reg, state_next;
    logic [RW-1:0]           row_reg, row_next, col_reg, col_next;
    logic                    issue_reg, issue_next, pend_reg, pend_next;
    logic [AW-1:0]           pend_addr_reg, pend_addr_next;
    logic [31:0]             gen_reg, gen_next;
    logic                    mode_reg, mode_next;
    logic [RW-1:0]           cur_row_reg, cur_row_next, cur_col_reg, cur_col_next;
    logic                    old_reg, old_next;
    logic [CW-1:0]           top_reg, top_next, sp_reg, sp_next;
    logic [1:0]              nb_idx_reg, nb_idx_next;
    logic [2:0]              phase_reg, phase_next;
    logic                    sa_reg [7];
    logic                    ta_reg [7];
    logic                    sa_next [7];
    logic                    ta_next [7];
    logic signed [D_W-1:0]   d0_reg, d0_next, d1_reg, d1_next;
    logic signed [D_W-1:0]   d2_reg, d2_next, d3_reg, d3_next;
    logic [2:0]              tix_reg, tix_next;
    logic                    stage_reg, stage_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic                    keep_reg, keep_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic                    done_reg, done_next, accepted_reg, accepted_next;
    logic [OUT_W-1:0]        size_reg, size_next, mag_reg, mag_next;

    logic [31:0]             gen_step;
    logic [15:0]             u;
    logic                    last_pos;
    logic                    sweep_done;
    logic [AW-1:0]           sweep_addr;
    logic [AW-1:0]           nb_addr;
    logic [AW-1:0]           sum_addr;
    logic                    join_site;
    logic [CW-1:0]           top_after;
    logic [CW-1:0]           sp_inc;
    logic                    grow_end;
    logic [1:0]              n_eff;
    logic signed [MUL_A_W-1:0] coef;
    logic signed [MUL_B_W-1:0] dsel;
    logic                    neg;
    logic [2:0]              last_tix;
    logic                    nonpos;
    logic [MUL_A_W-1:0]      ec;
    logic                    x_pass;
    logic [16+AW:0]          seed_prod;
    logic                    va [7];
    logic                    vt [7];
    logic signed [3:0]       c1, c2, c3, c0;

    assign gen_step   = xorshift32(gen_reg);
    assign u          = gen_step[31:16];
    assign last_pos   = (row_reg == LAST) && (col_reg == LAST);
    assign sweep_done = !issue_reg && !pend_reg;
    assign sweep_addr = {row_reg, col_reg};
    assign seed_prod  = (17 + AW)'(u) * (17 + AW)'(NSITES);

    always_comb
    begin
        unique case (nb_idx_reg)
            2'd0:    nb_addr = {dec1(cur_row_reg), cur_col_reg};
            2'd1:    nb_addr = {inc1(cur_row_reg), cur_col_reg};
            2'd2:    nb_addr = {cur_row_reg, dec1(cur_col_reg)};
            default: nb_addr = {cur_row_reg, inc1(cur_col_reg)};
        endcase
    end

    // Offsets of the seven sites that one site's energy terms touch.
    always_comb
    begin
        unique case (phase_reg)
            3'd1:    sum_addr = {inc1(row_reg), col_reg};
            3'd2:    sum_addr = {row_reg, inc1(col_reg)};
            3'd3:    sum_addr = {inc1(row_reg), inc1(col_reg)};
            3'd4:    sum_addr = {dec1(row_reg), inc1(col_reg)};
            3'd5:    sum_addr = {inc1(inc1(row_reg)), col_reg};
            3'd6:    sum_addr = {row_reg, inc1(inc1(col_reg))};
            default: sum_addr = {row_reg, col_reg};
        endcase
    end

    assign join_site = (trial_rd == old_reg) && (u < cfg.add_probability);
    assign top_after = join_site ? top_reg + 1'b1 : top_reg;
    assign sp_inc    = sp_reg + 1'b1;
    assign grow_end  = sp_inc > top_after;

    // Term list of the two energy sums, one product per step.
    always_comb
    begin
        n_eff    = (cfg.coupling_order == 2'd0) ? 2'd1 : cfg.coupling_order;
        coef     = '0;
        dsel     = '0;
        neg      = 1'b0;
        last_tix = stage_reg ? 3'd4 : 3'd1;
        unique case ({stage_reg, tix_reg})
            4'b0_000:
            begin
                coef = (n_eff >= 2'd2) ? MUL_A_W'($signed(cfg.coupling_second)) : '0;
                dsel = MUL_B_W'(d2_reg);
                neg  = 1'b1;
            end
            4'b0_001:
            begin
                coef = (n_eff == 2'd3) ? MUL_A_W'($signed(cfg.coupling_third)) : '0;
                dsel = MUL_B_W'(d3_reg);
                neg  = 1'b1;
            end
            4'b1_000:
            begin
                coef = MUL_A_W'(4096);
                dsel = MUL_B_W'(d1_reg);
                neg  = 1'b1;
            end
            4'b1_001:
            begin
                coef = MUL_A_W'($signed(cfg.triple_coupling));
                dsel = MUL_B_W'(d0_reg);
                neg  = 1'b1;
            end
            4'b1_010:
            begin
                coef = MUL_A_W'($signed(cfg.coupling_first));
                dsel = MUL_B_W'(d1_reg);
            end
            4'b1_011:
            begin
                coef = (n_eff >= 2'd2) ? MUL_A_W'($signed(cfg.coupling_second)) : '0;
                dsel = MUL_B_W'(d2_reg);
            end
            4'b1_100:
            begin
                coef = (n_eff == 2'd3) ? MUL_A_W'($signed(cfg.coupling_third)) : '0;
                dsel = MUL_B_W'(d3_reg);
            end
            default:
            begin
                coef = '0;
                dsel = '0;
            end
        endcase
    end

    // An energy at or above 2^28 already gives x >= 16 for any nonzero beta.
    assign nonpos = acc_reg[ACC_W-1] || (acc_reg == '0) || (cfg.inverse_temperature == '0);
    assign ec     = ($unsigned(acc_reg) >= X_LIMIT) ? MUL_A_W'(X_LIMIT)
                                                    : MUL_A_W'(acc_reg[27:0]);
    assign x_pass = (mul_p < PROD_W'(X_LIMIT)) && (u < EXP_TABLE[mul_p[27:20]]);

    always_comb
    begin
        if (state_reg == ST_SCALE)
        begin
            mul_a = $signed(ec);
            mul_b = $signed(MUL_B_W'(cfg.inverse_temperature));
        end
        else
        begin
            mul_a = coef;
            mul_b = dsel;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            va[i] = sa_reg[i];
            vt[i] = ta_reg[i];
        end
        va[6] = spin_rd;
        vt[6] = trial_rd;
        c1 = psum(vt[0], vt[1], vt[2]) - psum(va[0], va[1], va[2]);
        c2 = psum(vt[0], vt[4], vt[3]) - psum(va[0], va[4], va[3]);
        c3 = psum(vt[0], vt[5], vt[6]) - psum(va[0], va[5], va[6]);
        c0 = ((vt[0] ^ vt[1] ^ vt[2] ^ vt[3]) ? -4'sd1 : 4'sd1)
           - ((va[0] ^ va[1] ^ va[2] ^ va[3]) ? -4'sd1 : 4'sd1);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:    if (last_pos) state_next = ST_IDLE;
            ST_IDLE:     if (start) state_next = mode ? ST_SEED : ST_RAND;
            ST_RAND:     if (last_pos) state_next = ST_IDLE;
            ST_SEED:     state_next = ST_COPY;
            ST_COPY:     if (sweep_done) state_next = ST_PUSH0;
            ST_PUSH0:    state_next = ST_NB_RD;
            ST_NB_RD:    state_next = ST_NB_CHK;
            ST_NB_CHK:
            begin
                if (nb_idx_reg == 2'd3)
                begin
                    state_next = grow_end ? ST_SUM : ST_POP;
                end
                else
                begin
                    state_next = ST_NB_RD;
                end
            end
            ST_POP:      state_next = ST_POP_WAIT;
            ST_POP_WAIT: state_next = ST_NB_RD;
            ST_SUM:      if (phase_reg == 3'd7 && last_pos) state_next = ST_MAC;
            ST_MAC:      state_next = ST_MAC_ACC;
            ST_MAC_ACC:  state_next = (tix_reg == last_tix) ? ST_SCALE : ST_MAC;
            ST_SCALE:
            begin
                if (!nonpos)
                begin
                    state_next = ST_TEST;
                end
                else
                begin
                    state_next = stage_reg ? ST_FINAL : ST_MAC;
                end
            end
            ST_TEST:     state_next = (x_pass && !stage_reg) ? ST_MAC : ST_FINAL;
            ST_FINAL:    if (sweep_done) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb
    begin
        row_next       = row_reg;
        col_next       = col_reg;
        issue_next     = issue_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        gen_next       = gen_reg;
        mode_next      = mode_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        old_next       = old_reg;
        top_next       = top_reg;
        sp_next        = sp_reg;
        nb_idx_next    = nb_idx_reg;
        phase_next     = phase_reg;
        sa_next        = sa_reg;
        ta_next        = ta_reg;
        d0_next        = d0_reg;
        d1_next        = d1_reg;
        d2_next        = d2_reg;
        d3_next        = d3_reg;
        tix_next       = tix_reg;
        stage_next     = stage_reg;
        acc_next       = acc_reg;
        keep_next      = keep_reg;
        cnt_next       = cnt_reg;
        done_next      = 1'b0;
        accepted_next  = accepted_reg;
        size_next      = size_reg;
        mag_next       = mag_reg;
        mem_ctl        = '0;
        spin_ra        = sweep_addr;
        spin_wa        = sweep_addr;
        trial_ra       = sweep_addr;
        trial_wa       = pend_addr_reg;
        stack_ra       = sp_reg[AW-1:0];
        stack_wa       = '0;
        stack_wd       = {cur_row_reg, cur_col_reg};

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_ctl.spin_we = 1'b1;
                mem_ctl.spin_wd = 1'b0;
                col_next = (col_reg == LAST) ? '0 : col_reg + 1'b1;
                row_next = (col_reg == LAST) ? row_reg + 1'b1 : row_reg;
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    gen_next  = (random_seed == '0) ? 32'd1 : random_seed;
                    mode_next = mode;
                    row_next  = '0;
                    col_next  = '0;
                    cnt_next  = '0;
                end
            end
            ST_RAND:
            begin
                gen_next        = gen_step;
                mem_ctl.spin_we = 1'b1;
                mem_ctl.spin_wd = u[15];
                cnt_next        = cnt_reg + CW'(!u[15]);
                col_next = (col_reg == LAST) ? '0 : col_reg + 1'b1;
                row_next = (col_reg == LAST) ? row_reg + 1'b1 : row_reg;
                if (last_pos)
                begin
                    done_next     = 1'b1;
                    accepted_next = 1'b1;
                    size_next     = '0;
                    mag_next      = mag_of(cnt_next);
                end
            end
            ST_SEED:
            begin
                // The seed index is row-major, so its upper bits are the row.
                gen_next     = gen_step;
                cur_row_next = seed_prod[16 + RW +: RW];
                cur_col_next = seed_prod[16 +: RW];
                row_next     = '0;
                col_next     = '0;
                issue_next   = 1'b1;
                pend_next    = 1'b0;
            end
            ST_COPY:
            begin
                if (issue_reg)
                begin
                    pend_next      = 1'b1;
                    pend_addr_next = sweep_addr;
                    issue_next     = !last_pos;
                    col_next = (col_reg == LAST) ? '0 : col_reg + 1'b1;
                    row_next = (col_reg == LAST) ? row_reg + 1'b1 : row_reg;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    mem_ctl.trial_we = 1'b1;
                    mem_ctl.trial_wd = spin_rd;
                    if (pend_addr_reg == {cur_row_reg, cur_col_reg})
                    begin
                        old_next = spin_rd;
                    end
                end
            end
            ST_PUSH0:
            begin
                mem_ctl.stack_we = 1'b1;
                stack_wa         = '0;
                mem_ctl.trial_we = 1'b1;
                mem_ctl.trial_wd = !old_reg;
                trial_wa         = {cur_row_reg, cur_col_reg};
                top_next         = '0;
                sp_next          = '0;
                nb_idx_next      = '0;
            end
            ST_NB_RD:
            begin
                trial_ra = nb_addr;
            end
            ST_NB_CHK:
            begin
                if (trial_rd == old_reg)
                begin
                    gen_next = gen_step;
                end
                if (join_site)
                begin
                    top_next         = top_after;
                    mem_ctl.stack_we = 1'b1;
                    stack_wa         = top_after[AW-1:0];
                    stack_wd         = nb_addr;
                    mem_ctl.trial_we = 1'b1;
                    mem_ctl.trial_wd = !old_reg;
                    trial_wa         = nb_addr;
                end
                nb_idx_next = nb_idx_reg + 1'b1;
                if (nb_idx_reg == 2'd3)
                begin
                    sp_next = sp_inc;
                    if (grow_end)
                    begin
                        row_next   = '0;
                        col_next   = '0;
                        phase_next = '0;
                        d0_next    = '0;
                        d1_next    = '0;
                        d2_next    = '0;
                        d3_next    = '0;
                    end
                end
            end
            ST_POP:
            begin
                stack_ra = sp_reg[AW-1:0];
            end
            ST_POP_WAIT:
            begin
                cur_row_next = stack_rd[AW-1:RW];
                cur_col_next = stack_rd[RW-1:0];
            end
            ST_SUM:
            begin
                spin_ra  = sum_addr;
                trial_ra = sum_addr;
                if (phase_reg != 3'd0)
                begin
                    sa_next[3'(phase_reg - 3'd1)] = spin_rd;
                    ta_next[3'(phase_reg - 3'd1)] = trial_rd;
                end
                phase_next = phase_reg + 1'b1;
                if (phase_reg == 3'd7)
                begin
                    d0_next  = d0_reg + D_W'(c0);
                    d1_next  = d1_reg + D_W'(c1);
                    d2_next  = d2_reg + D_W'(c2);
                    d3_next  = d3_reg + D_W'(c3);
                    col_next = (col_reg == LAST) ? '0 : col_reg + 1'b1;
                    row_next = (col_reg == LAST) ? row_reg + 1'b1 : row_reg;
                    if (last_pos)
                    begin
                        tix_next   = '0;
                        stage_next = 1'b0;
                        acc_next   = '0;
                    end
                end
            end
            ST_MAC:
            begin
            end
            ST_MAC_ACC:
            begin
                acc_next = neg ? acc_reg - ACC_W'(mul_p) : acc_reg + ACC_W'(mul_p);
                tix_next = tix_reg + 1'b1;
            end
            ST_SCALE:
            begin
                if (nonpos)
                begin
                    if (stage_reg)
                    begin
                        keep_next  = 1'b1;
                        row_next   = '0;
                        col_next   = '0;
                        issue_next = 1'b1;
                        pend_next  = 1'b0;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        stage_next = 1'b1;
                        tix_next   = '0;
                        acc_next   = '0;
                    end
                end
            end
            ST_TEST:
            begin
                gen_next = gen_step;
                if (x_pass && !stage_reg)
                begin
                    stage_next = 1'b1;
                    tix_next   = '0;
                    acc_next   = '0;
                end
                else
                begin
                    keep_next  = x_pass;
                    row_next   = '0;
                    col_next   = '0;
                    issue_next = 1'b1;
                    pend_next  = 1'b0;
                    cnt_next   = '0;
                end
            end
            ST_FINAL:
            begin
                trial_ra = sweep_addr;
                spin_wa  = pend_addr_reg;
                if (issue_reg)
                begin
                    pend_next      = 1'b1;
                    pend_addr_next = sweep_addr;
                    issue_next     = !last_pos;
                    col_next = (col_reg == LAST) ? '0 : col_reg + 1'b1;
                    row_next = (col_reg == LAST) ? row_reg + 1'b1 : row_reg;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    mem_ctl.spin_we = 1'b1;
                    mem_ctl.spin_wd = keep_reg ? trial_rd : spin_rd;
                    cnt_next = cnt_reg + CW'(!mem_ctl.spin_wd);
                end
                if (sweep_done)
                begin
                    done_next     = 1'b1;
                    accepted_next = keep_reg;
                    size_next     = OUT_W'(top_reg + 1'b1);
                    mag_next      = mag_of(cnt_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            row_reg    <= '0;
            col_reg    <= '0;
            issue_reg  <= 1'b0;
            pend_reg   <= 1'b0;
            gen_reg    <= 32'd1;
            mode_reg   <= 1'b0;
            top_reg    <= '0;
            sp_reg     <= '0;
            nb_idx_reg <= '0;
            phase_reg  <= '0;
            tix_reg    <= '0;
            stage_reg  <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            issue_reg  <= issue_next;
            pend_reg   <= pend_next;
            gen_reg    <= gen_next;
            mode_reg   <= mode_next;
            top_reg    <= top_next;
            sp_reg     <= sp_next;
            nb_idx_reg <= nb_idx_next;
            phase_reg  <= phase_next;
            tix_reg    <= tix_next;
            stage_reg  <= stage_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
        cur_row_reg   <= cur_row_next;
        cur_col_reg   <= cur_col_next;
        old_reg       <= old_next;
        sa_reg        <= sa_next;
        ta_reg        <= ta_next;
        d0_reg        <= d0_next;
        d1_reg        <= d1_next;
        d2_reg        <= d2_next;
        d3_reg        <= d3_next;
        acc_reg       <= acc_next;
        keep_reg      <= keep_next;
        cnt_reg       <= cnt_next;
        accepted_reg  <= accepted_next;
        size_reg      <= size_next;
        mag_reg       <= mag_next;
    end

    assign busy              = (state_reg != ST_IDLE);
    assign done              = done_reg;
    assign accepted          = accepted_reg;
    assign cluster_size      = size_reg;
    assign abs_magnetization = mag_reg;

    `ASSERT_IMPLIES(a_top_in_range, clk, rst_n, 1'b1, top_reg < CW'(NSITES))
    `ASSERT_IMPLIES(a_sp_within_stack, clk, rst_n, state_reg == ST_NB_RD, sp_reg <= top_reg)
    `ASSERT_NEXT(a_done_single, clk, rst_n, done_reg, !done_reg)
    `ASSERT_IMPLIES(a_rand_result, clk, rst_n, done_reg && !mode_reg,
                    accepted_reg && (size_reg == '0))

endmodule

@@ sv/wolff_cluster_two_stage_accept_top.sv @@
// ----------------------------------------------------------------------------
// wolff_cluster_two_stage_accept_top
// Two-stage Wolff cluster update on a torus of spins, with config registers.
// ----------------------------------------------------------------------------
// A cluster item's run time grows with the cluster size but is set mostly by
// the energy sweep, which reads seven sites per site (the site itself and six
// neighbors) over one read port of each lattice memory.
// One item at a time: busy is high from acceptance until the done strobe.
// After reset, busy stays high while the lattice is set to all +1;
// configuration writes are taken throughout. The receiver cannot stall.
module wolff_cluster_two_stage_accept_top
    import wcta_pkg::*;
#(
    parameter int SIDE = WCTA_SIDE
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             mode,
    input  logic [31:0]      random_seed,
    output logic             done,
    output logic             accepted,
    output logic [OUT_W-1:0] cluster_size,
    output logic [OUT_W-1:0] abs_magnetization,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [15:0]      cfg_data
);

    localparam int RW = $clog2(SIDE);
    localparam int AW = 2 * RW;

    cfg_t cfg_reg, cfg_next;

    mem_ctl_t                  mem_ctl;
    logic [AW-1:0]             spin_ra, spin_wa, trial_ra, trial_wa;
    logic [AW-1:0]             stack_ra, stack_wa, stack_wd, stack_rd;
    logic                      spin_rd, trial_rd;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ADD_PROB:   cfg_next.add_probability     = cfg_data;
                CFG_COUPLING_1: cfg_next.coupling_first      = cfg_data;
                CFG_COUPLING_2: cfg_next.coupling_second     = cfg_data;
                CFG_COUPLING_3: cfg_next.coupling_third      = cfg_data;
                CFG_TRIPLE:     cfg_next.triple_coupling     = cfg_data;
                CFG_INV_TEMP:   cfg_next.inverse_temperature = cfg_data;
                CFG_ORDER:      cfg_next.coupling_order      = cfg_data[1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.add_probability     <= 16'd0;
            cfg_reg.coupling_first      <= 16'd4096;
            cfg_reg.coupling_second     <= 16'd0;
            cfg_reg.coupling_third      <= 16'd0;
            cfg_reg.triple_coupling     <= 16'd819;
            cfg_reg.inverse_temperature <= 16'd1643;
            cfg_reg.coupling_order      <= 2'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    wcta_ctrl #(
        .SIDE(SIDE)
    ) u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .mode             (mode),
        .random_seed      (random_seed),
        .cfg              (cfg_reg),
        .busy             (busy),
        .done             (done),
        .accepted         (accepted),
        .cluster_size     (cluster_size),
        .abs_magnetization(abs_magnetization),
        .mem_ctl          (mem_ctl),
        .spin_ra          (spin_ra),
        .spin_wa          (spin_wa),
        .trial_ra         (trial_ra),
        .trial_wa         (trial_wa),
        .stack_ra         (stack_ra),
        .stack_wa         (stack_wa),
        .stack_wd         (stack_wd),
        .spin_rd          (spin_rd),
        .trial_rd         (trial_rd),
        .stack_rd         (stack_rd),
        .mul_a            (mul_a),
        .mul_b            (mul_b),
        .mul_p            (mul_p)
    );

    wcta_mem #(
        .SIDE(SIDE)
    ) u_mem (
        .clk     (clk),
        .mem_ctl (mem_ctl),
        .spin_ra (spin_ra),
        .spin_wa (spin_wa),
        .trial_ra(trial_ra),
        .trial_wa(trial_wa),
        .stack_ra(stack_ra),
        .stack_wa(stack_wa),
        .stack_wd(stack_wd),
        .spin_rd (spin_rd),
        .trial_rd(trial_rd),
        .stack_rd(stack_rd)
    );

    wcta_mult u_mult (
        .clk  (clk),
        .mul_a(mul_a),
        .mul_b(mul_b),
        .mul_p(mul_p)
    );

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the two-stage Wolff cluster block. It runs directed and random
// lattice items under a range of register settings. A behavioral copy of the
// lattice, the generator and the accept stages predicts every result, and a
// checker compares each done strobe with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import wcta_pkg::*;

    localparam int NSITE = WCTA_SIDE * WCTA_SIDE;
    localparam longint unsigned STEP_Q32 = 64'd4034748382;
    localparam longint CYCLE_LIMIT = 64'd12000000;
    localparam logic MODE_RANDOMIZE = 1'b0;
    localparam logic MODE_CLUSTER = 1'b1;
    localparam logic [2:0] CFG_UNUSED_INDEX = 3'd7;

    typedef byte spin_grid_t [NSITE];

    typedef struct {
        logic             accepted;
        logic [OUT_W-1:0] cluster_size;
        logic [OUT_W-1:0] abs_magnetization;
    } outcome_t;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic             mode;
    logic [31:0]      random_seed;
    logic             done;
    logic             accepted;
    logic [OUT_W-1:0] cluster_size;
    logic [OUT_W-1:0] abs_magnetization;
    logic             cfg_we;
    logic [2:0]       cfg_index;
    logic [15:0]      cfg_data;

    // Predictor state.
    spin_grid_t  model_spins;
    spin_grid_t  model_trial;
    int          model_stack [NSITE];
    logic [31:0] model_gen;
    logic [15:0] exp_q16 [256];
    logic [15:0] m_add_prob;
    logic [15:0] m_j1;
    logic [15:0] m_j2;
    logic [15:0] m_j3;
    logic [15:0] m_k;
    logic [15:0] m_beta;
    logic [1:0]  m_order;

    outcome_t outcome_q [$];
    int       mismatches;
    longint   cycles;

    wolff_cluster_two_stage_accept_top dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .mode(mode),
        .random_seed(random_seed),
        .done(done),
        .accepted(accepted),
        .cluster_size(cluster_size),
        .abs_magnetization(abs_magnetization),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int site_at(int r, int c);
        return ((r % WCTA_SIDE) * WCTA_SIDE) + (c % WCTA_SIDE);
    endfunction

    function automatic logic [15:0] draw_uniform();
        logic [31:0] x;
        x = model_gen;
        x = x ^ (x << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        model_gen = x;
        return x[31:16];
    endfunction

    // Index 0 holds the plaquette sum, 1..3 the pair sums of each order.
    function automatic void energy_sums(input spin_grid_t s, output longint o[4]);
        int v;
        int dn;
        int rt;
        int dr;
        int ur;
        for (int k = 0; k < 4; k++)
            o[k] = 0;
        for (int r = 0; r < WCTA_SIDE; r++)
        begin
            for (int c = 0; c < WCTA_SIDE; c++)
            begin
                v  = s[site_at(r, c)];
                dn = s[site_at(r + 1, c)];
                rt = s[site_at(r, c + 1)];
                dr = s[site_at(r + 1, c + 1)];
                ur = s[site_at(r + WCTA_SIDE - 1, c + 1)];
                o[1] += v * (dn + rt);
                o[2] += v * (ur + dr);
                o[3] += v * (s[site_at(r + 2, c)] + s[site_at(r, c + 2)]);
                o[0] += v * dn * rt * dr;
            end
        end
    endfunction

    function automatic bit stage_passes(longint x);
        logic [15:0] u;
        if (x <= 0)
            return 1'b1;
        u = draw_uniform();
        if (x >= (longint'(16) << 24))
            return 1'b0;
        return u < exp_q16[x >> 20];
    endfunction

    function automatic logic [OUT_W-1:0] lattice_magnetization();
        int m;
        m = 0;
        for (int i = 0; i < NSITE; i++)
            m += model_spins[i];
        if (m < 0)
            m = -m;
        return m[OUT_W-1:0];
    endfunction

    function automatic outcome_t predict_outcome(logic item_mode, logic [31:0] seed);
        outcome_t res;
        int       site;
        int       top;
        int       sp;
        int       r;
        int       c;
        int       nb;
        int       n;
        byte      old;
        int       nbs [4];
        longint   a [4];
        longint   t [4];
        longint   d [4];
        longint   j [4];
        longint   e1;
        longint   e2;
        longint   beta;
        bit       keep;
        model_gen = (seed == 32'd0) ? 32'd1 : seed;
        if (item_mode == MODE_RANDOMIZE)
        begin
            for (int i = 0; i < NSITE; i++)
                model_spins[i] = (draw_uniform() < 16'd32768) ? 8'sd1 : -8'sd1;
            res.accepted = 1'b1;
            res.cluster_size = '0;
            res.abs_magnetization = lattice_magnetization();
            return res;
        end
        site = int'((longint'(draw_uniform()) * NSITE) >> 16) % NSITE;
        model_trial = model_spins;
        old = model_trial[site];
        model_stack[0] = site;
        model_trial[site] = -old;
        top = 0;
        sp = 0;
        forever
        begin
            r = site / WCTA_SIDE;
            c = site % WCTA_SIDE;
            // Neighbors are tried up, down, left, right.
            nbs[0] = site_at(r + WCTA_SIDE - 1, c);
            nbs[1] = site_at(r + 1, c);
            nbs[2] = site_at(r, c + WCTA_SIDE - 1);
            nbs[3] = site_at(r, c + 1);
            for (int q = 0; q < 4; q++)
            begin
                nb = nbs[q];
                if (model_trial[nb] == old && draw_uniform() < m_add_prob)
                begin
                    top++;
                    if (top < NSITE)
                        model_stack[top] = nb;
                    model_trial[nb] = -old;
                end
            end
            sp++;
            if (sp > top || sp >= NSITE)
                break;
            site = model_stack[sp];
        end
        energy_sums(model_spins, a);
        energy_sums(model_trial, t);
        for (int k = 0; k < 4; k++)
            d[k] = t[k] - a[k];
        j[0] = 0;
        j[1] = longint'($signed(m_j1));
        j[2] = longint'($signed(m_j2));
        j[3] = longint'($signed(m_j3));
        n = (m_order == 2'd0) ? 1 : int'(m_order);
        beta = longint'(m_beta);
        e1 = 0;
        for (int k = 2; k <= n; k++)
            e1 -= j[k] * d[k];
        e2 = -4096 * d[1] - longint'($signed(m_k)) * d[0];
        for (int k = 1; k <= n; k++)
            e2 += j[k] * d[k];
        keep = 1'b0;
        if (stage_passes(e1 * beta))
            keep = stage_passes(e2 * beta);
        if (keep)
            model_spins = model_trial;
        res.accepted = keep;
        res.cluster_size = OUT_W'(top + 1);
        res.abs_magnetization = lattice_magnetization();
        return res;
    endfunction

    // Result checker: every done strobe must match the oldest prediction.
    always @(posedge clk)
    begin
        outcome_t exp_res;
        if (rst_n && done)
        begin
            if (outcome_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: acc=%0d size=%0d mag=%0d",
                             accepted, cluster_size, abs_magnetization);
            end
            else
            begin
                exp_res = outcome_q.pop_front();
                if (accepted !== exp_res.accepted || cluster_size !== exp_res.cluster_size
                    || abs_magnetization !== exp_res.abs_magnetization)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp acc=%0d size=%0d mag=%0d, got acc=%0d size=%0d mag=%0d",
                                 exp_res.accepted, exp_res.cluster_size,
                                 exp_res.abs_magnetization, accepted, cluster_size,
                                 abs_magnetization);
                end
            end
        end
    end

    task automatic build_exp_lut();
        longint unsigned e;
        longint unsigned rnd;
        e = 64'd1 << 32;
        for (int i = 0; i < 256; i++)
        begin
            rnd = (e + 64'h8000) >> 16;
            exp_q16[i] = (rnd > 64'd65535) ? 16'hFFFF : rnd[15:0];
            e = (e * STEP_Q32 + (64'd1 << 31)) >> 32;
        end
    endtask

    // Leaves cfg_we high; end_cfg_burst lowers it after the last write.
    task automatic cfg_write(logic [2:0] idx, logic [15:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            CFG_ADD_PROB:   m_add_prob = value;
            CFG_COUPLING_1: m_j1 = value;
            CFG_COUPLING_2: m_j2 = value;
            CFG_COUPLING_3: m_j3 = value;
            CFG_TRIPLE:     m_k = value;
            CFG_INV_TEMP:   m_beta = value;
            CFG_ORDER:      m_order = value[1:0];
            default:        ;
        endcase
        @(posedge clk);
    endtask

    task automatic end_cfg_burst();
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (outcome_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(20, 200);
        if ($urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 4);
    endfunction

    // Sends one item and records its prediction at the accepting edge.
    task automatic send_item(logic item_mode, logic [31:0] seed);
        @(posedge clk);
        repeat (pick_gap()) @(posedge clk);
        start <= 1'b1;
        mode <= item_mode;
        random_seed <= seed;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        outcome_q.push_back(predict_outcome(item_mode, seed));
        start <= 1'b0;
        mode <= $urandom_range(0, 1);
        random_seed <= $urandom;
    endtask

    task automatic test_reset_defaults();
        send_item(MODE_CLUSTER, 32'd0);
        send_item(MODE_CLUSTER, 32'hFFFF_FFFF);
        send_item(MODE_CLUSTER, $urandom);
    endtask

    task automatic test_randomize();
        send_item(MODE_RANDOMIZE, 32'd0);
        send_item(MODE_RANDOMIZE, 32'hFFFF_FFFF);
        send_item(MODE_RANDOMIZE, $urandom);
        send_item(MODE_CLUSTER, $urandom);
    endtask

    task automatic test_bond_extremes();
        wait_drained();
        cfg_write(CFG_ADD_PROB, 16'hFFFF);
        end_cfg_burst();
        send_item(MODE_CLUSTER, $urandom);
        send_item(MODE_RANDOMIZE, $urandom);
        send_item(MODE_CLUSTER, $urandom);
        wait_drained();
        cfg_write(CFG_ADD_PROB, 16'h8000);
        end_cfg_burst();
        send_item(MODE_CLUSTER, $urandom);
        send_item(MODE_CLUSTER, $urandom);
    endtask

    // Orders zero, two and three, extreme couplings and a huge exponent.
    task automatic test_orders_and_exponent();
        wait_drained();
        cfg_write(CFG_ORDER, 16'd0);
        cfg_write(CFG_COUPLING_2, 16'h7FFF);
        cfg_write(CFG_COUPLING_3, 16'h8000);
        end_cfg_burst();
        send_item(MODE_CLUSTER, $urandom);
        wait_drained();
        cfg_write(CFG_ORDER, 16'd3);
        cfg_write(CFG_COUPLING_1, 16'h8000);
        cfg_write(CFG_TRIPLE, 16'h7FFF);
        cfg_write(CFG_INV_TEMP, 16'hFFFF);
        end_cfg_burst();
        send_item(MODE_CLUSTER, $urandom);
        send_item(MODE_CLUSTER, $urandom);
        wait_drained();
        cfg_write(CFG_ORDER, 16'd2);
        cfg_write(CFG_INV_TEMP, 16'd0);
        // A write past the last register must leave every register alone.
        cfg_write(CFG_UNUSED_INDEX, 16'hFFFF);
        end_cfg_burst();
        send_item(MODE_CLUSTER, $urandom);
        send_item(MODE_CLUSTER, $urandom);
    endtask

    task automatic test_random_items();
        for (int i = 0; i < 84; i++)
        begin
            if (i % 12 == 0)
            begin
                wait_drained();
                cfg_write(CFG_ADD_PROB, ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                        : 16'($urandom_range(16384, 52000)));
                cfg_write(CFG_COUPLING_1, 16'($urandom));
                cfg_write(CFG_COUPLING_2, 16'($urandom));
                cfg_write(CFG_COUPLING_3, 16'($urandom));
                cfg_write(CFG_TRIPLE, 16'($urandom));
                cfg_write(CFG_INV_TEMP, ($urandom_range(0, 2) == 0) ? 16'($urandom)
                                        : 16'($urandom_range(0, 8191)));
                cfg_write(CFG_ORDER, 16'($urandom));
                if ($urandom_range(0, 3) == 0)
                    cfg_write(CFG_UNUSED_INDEX, 16'($urandom));
                end_cfg_burst();
            end
            send_item(($urandom_range(0, 7) == 0) ? MODE_RANDOMIZE : MODE_CLUSTER, $urandom);
        end
    endtask

    initial
    begin
        cycles = 0;
        mismatches = 0;
        rst_n <= 1'b0;
        start <= 1'b0;
        mode <= MODE_RANDOMIZE;
        random_seed <= '0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_ADD_PROB;
        cfg_data <= '0;
        build_exp_lut();
        for (int i = 0; i < NSITE; i++)
            model_spins[i] = 8'sd1;
        m_add_prob = 16'd0;
        m_j1 = 16'd4096;
        m_j2 = 16'd0;
        m_j3 = 16'd0;
        m_k = 16'd819;
        m_beta = 16'd1643;
        m_order = 2'd1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_randomize();
        test_bond_extremes();
        test_orders_and_exponent();
        test_random_items();

        wait_drained();
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
